// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, register indexes, microcode format and program of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int unsigned OPND_W    = 32;
  localparam int unsigned MUL_CNT_W = $clog2(OPND_W);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EXP_WIDTH_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_REDUCE = 3'd1;
  localparam step_t STEP_TEST   = 3'd2;
  localparam step_t STEP_MULACC = 3'd3;
  localparam step_t STEP_SHIFT  = 3'd4;
  localparam step_t STEP_SQR    = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_REDUCE,
    OP_TEST,
    OP_MULACC,
    OP_SHIFT,
    OP_SQR,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_BIT_CLR,
    COND_LAST
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic mul_done;
    logic out_free;
    logic bit_clr;
    logic last;
  } status_t;

  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    unique case (pc)
      STEP_IDLE:   w = '{op: OP_ACCEPT, cond: COND_NEVER,   target: STEP_IDLE};
      STEP_REDUCE: w = '{op: OP_REDUCE, cond: COND_NEVER,   target: STEP_IDLE};
      STEP_TEST:   w = '{op: OP_TEST,   cond: COND_BIT_CLR, target: STEP_SHIFT};
      STEP_MULACC: w = '{op: OP_MULACC, cond: COND_NEVER,   target: STEP_IDLE};
      STEP_SHIFT:  w = '{op: OP_SHIFT,  cond: COND_LAST,    target: STEP_EMIT};
      STEP_SQR:    w = '{op: OP_SQR,    cond: COND_ALWAYS,  target: STEP_TEST};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_ALWAYS,  target: STEP_IDLE};
      default:     w = '{op: OP_TEST,   cond: COND_ALWAYS,  target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// most significant first, with the running remainder kept below the modulus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [mexp_pkg::OPND_W-1:0]  a_i,
  input  wire logic [mexp_pkg::OPND_W-1:0]  b_i,
  input  wire logic [mexp_pkg::OPND_W-1:0]  mod_i,
  output logic                              done_o,
  output logic [mexp_pkg::OPND_W-1:0]       prod_o
);

  localparam int unsigned W = mexp_pkg::OPND_W;

  logic                            busy_q;
  logic                            done_q;
  logic [mexp_pkg::MUL_CNT_W-1:0]  cnt_q;
  logic [W-1:0]                    a_q;
  logic [W-1:0]                    b_q;
  logic [W-1:0]                    r_q;
  logic [W-1:0]                    r_d;

  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;

  always_comb begin
    m1  = {2'b00, mod_i};
    m2  = {1'b0, mod_i, 1'b0};
    sum = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
    priority if (sum >= m2) begin
      r_d = W'(sum - m2);
    end else if (sum >= m1) begin
      r_d = W'(sum - m1);
    end else begin
      r_d = W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mexp_pkg::MUL_CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      b_q <= {b_q[W-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

`default_nettype wire

// ===== sv/mexp_seq.sv =====
// ----------------------------------------------------------------------------
// mexp_seq
// Microcode sequencer: step counter over the control program, holding a
// step until its operation completes, then branching or advancing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mexp_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mexp_pkg::status_t  status_i,
  output mexp_pkg::ucode_t        ctrl_o,
  output logic                    fire_o
);

  mexp_pkg::step_t  pc_q;
  mexp_pkg::step_t  pc_d;
  mexp_pkg::ucode_t word;
  logic             fire;
  logic             take;

  always_comb begin
    word = mexp_pkg::ucode_rom(pc_q);

    unique case (word.op)
      mexp_pkg::OP_ACCEPT: fire = status_i.start;
      mexp_pkg::OP_REDUCE,
      mexp_pkg::OP_MULACC,
      mexp_pkg::OP_SQR:    fire = status_i.mul_done;
      mexp_pkg::OP_EMIT:   fire = status_i.out_free;
      default:             fire = 1'b1;
    endcase

    unique case (word.cond)
      mexp_pkg::COND_NEVER:   take = 1'b0;
      mexp_pkg::COND_ALWAYS:  take = 1'b1;
      mexp_pkg::COND_BIT_CLR: take = status_i.bit_clr;
      mexp_pkg::COND_LAST:    take = status_i.last;
      default:                take = 1'b0;
    endcase

    pc_d = pc_q;
    if (fire) begin
      pc_d = take ? word.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mexp_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;
  assign fire_o = fire;

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Throughput: one word at a time; the next base is taken once the result is in
// the output register. Every modular product goes through one shared bit-serial
// multiplier. Reset clears the sequencer and output valid and sets modulus to 1
// and exponent to 0.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation driven by a
// microcoded sequencer over a shared modular multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [mexp_pkg::OPND_W-1:0]      base_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [mexp_pkg::OPND_W-1:0]           result_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mexp_pkg::OPND_W-1:0]      cfg_data_i
);

  localparam int unsigned W     = mexp_pkg::OPND_W;
  localparam int unsigned CNT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  logic [W-1:0]           modulus_q;
  logic [W-1:0]           exponent_q;
  logic [W-1:0]           base_q;
  logic [W-1:0]           acc_q;
  logic [W-1:0]           sq_q;
  logic [EXP_WIDTH-1:0]   e_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   launched_q;
  logic                   out_valid_q;
  logic [W-1:0]           result_q;

  mexp_pkg::ucode_t  ctrl;
  mexp_pkg::status_t status;
  logic              fire;
  logic              start;
  logic              is_mul;
  logic              mul_start;
  logic              mul_done;
  logic [W-1:0]      mul_a;
  logic [W-1:0]      mul_b;
  logic [W-1:0]      prod;
  logic [W-1:0]      one_mod;
  logic [EXP_WIDTH+W-1:0] e_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (ctrl.op != mexp_pkg::OP_ACCEPT);
  assign start       = in_valid_i && !in_stall_o;
  assign one_mod     = (modulus_q == W'(1)) ? '0 : W'(1);
  assign e_ext       = {{EXP_WIDTH{1'b0}}, exponent_q};

  always_comb begin
    is_mul = 1'b0;
    mul_a  = sq_q;
    mul_b  = sq_q;
    unique case (ctrl.op)
      mexp_pkg::OP_REDUCE: begin
        is_mul = 1'b1;
        mul_a  = one_mod;
        mul_b  = base_q;
      end
      mexp_pkg::OP_MULACC: begin
        is_mul = 1'b1;
        mul_b  = acc_q;
      end
      mexp_pkg::OP_SQR: begin
        is_mul = 1'b1;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  assign mul_start = is_mul && !launched_q;

  always_comb begin
    status.start    = start;
    status.mul_done = mul_done;
    status.out_free = !out_valid_q || !out_stall_i;
    status.bit_clr  = !e_q[0];
    status.last     = (cnt_q == CNT_W'(EXP_WIDTH - 1));
  end

  mexp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .fire_o   (fire)
  );

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .mod_i   (modulus_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= W'(1);
      exponent_q  <= '0;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mexp_pkg::REG_MODULUS) begin
          modulus_q <= cfg_data_i;
        end else if (cfg_index_i == mexp_pkg::REG_EXPONENT) begin
          exponent_q <= cfg_data_i;
        end
      end

      if (mul_start) begin
        launched_q <= 1'b1;
      end else if (mul_done) begin
        launched_q <= 1'b0;
      end

      if (fire && ctrl.op == mexp_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      unique case (ctrl.op)
        mexp_pkg::OP_ACCEPT: begin
          base_q <= base_i;
          acc_q  <= one_mod;
          e_q    <= e_ext[EXP_WIDTH-1:0];
          cnt_q  <= '0;
        end
        mexp_pkg::OP_REDUCE: sq_q  <= prod;
        mexp_pkg::OP_MULACC: acc_q <= prod;
        mexp_pkg::OP_SQR:    sq_q  <= prod;
        mexp_pkg::OP_SHIFT: begin
          e_q   <= e_q >> 1;
          cnt_q <= cnt_q + 1'b1;
        end
        mexp_pkg::OP_EMIT: result_q <= (modulus_q == '0) ? '0 : acc_q;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== sv/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mexp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [mexp_pkg::OPND_W-1:0]      result_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(result_o))
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPL(a_ready_on_result, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .result_o    (result_o)
);

`default_nettype wire
